/* rtl/cbpo_pkg.sv */
`default_nettype none
package cbpo_pkg;

  localparam int POS_W = 24;
  localparam int RAD_W = 16;

  typedef struct packed {
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic [RAD_W-1:0]        radius;
    logic signed [POS_W-1:0] box_min_x;
    logic signed [POS_W-1:0] box_min_y;
    logic signed [POS_W-1:0] box_max_x;
    logic signed [POS_W-1:0] box_max_y;
    logic                    box_solid;
    logic                    is_projectile;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic                    pushed;
    logic                    destroy;
  } out_t;

  // Per-item context that rides along every cell.
  typedef struct packed {
    logic                    vld;
    logic                    hit;
    logic                    proj;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic                    sx;
    logic                    sy;
    logic [RAD_W-1:0]        ax;
    logic [RAD_W-1:0]        ay;
    logic [RAD_W-1:0]        r;
  } ctx_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [31:0] rad;
    logic [17:0] rem;
    logic [15:0] root;
  } sq_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [15:0] s;
    logic [33:0] rx;
    logic [33:0] ry;
    logic [16:0] qx;
    logic [16:0] qy;
  } dv_t;

endpackage
`default_nettype wire

/* rtl/cbpo_sqrt_cell.sv */
`default_nettype none
module cbpo_sqrt_cell
  import cbpo_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  sq_t       d_i,
  output sq_t       d_o
);

  sq_t         d_r;
  sq_t         d_nxt;
  logic [19:0] shifted;
  logic [19:0] trial;

  always_comb begin
    shifted = {d_i.rem, d_i.rad[31:30]};
    trial   = {2'b00, d_i.root, 2'b01};
    d_nxt     = d_i;
    d_nxt.rad = {d_i.rad[29:0], 2'b00};
    if (shifted >= trial) begin
      d_nxt.rem  = 18'(shifted - trial);
      d_nxt.root = {d_i.root[14:0], 1'b1};
    end else begin
      d_nxt.rem  = shifted[17:0];
      d_nxt.root = {d_i.root[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.ctx.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

/* rtl/cbpo_div_cell.sv */
`default_nettype none
module cbpo_div_cell
  import cbpo_pkg::*;
#(
  parameter int K = 0
)
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  dv_t       d_i,
  output dv_t       d_o
);

  dv_t         d_r;
  dv_t         d_nxt;
  logic [34:0] dsh;
  logic        bx;
  logic        by;

  always_comb begin
    dsh = 35'({d_i.s, 1'b0}) << K;
    bx  = {1'b0, d_i.rx} >= dsh;
    by  = {1'b0, d_i.ry} >= dsh;
    d_nxt    = d_i;
    d_nxt.qx = {d_i.qx[15:0], bx};
    d_nxt.qy = {d_i.qy[15:0], by};
    if (bx) begin
      d_nxt.rx = 34'({1'b0, d_i.rx} - dsh);
    end
    if (by) begin
      d_nxt.ry = 34'({1'b0, d_i.ry} - dsh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.ctx.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

/* rtl/circle_box_push_out_top.sv */
`default_nettype none
// Circle against axis-aligned box push-out. One item enters per cycle and
// one result leaves per item, in order, through three front stages
// (clamp, squares, distance test), a chain of 16 square-root cells (one root
// bit each), a multiply stage, a chain of 17 divider cells (one quotient bit
// each, x and y side by side) and the saturating output register. A stall on
// the output holds the whole chain; while the output register is empty or
// being taken, input is accepted every cycle.
module circle_box_push_out_top
  import cbpo_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  in_t       in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int NSQ = 16;
  localparam int NDV = 17;

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 1: clamp and displacement
  logic signed [POS_W-1:0] clx;
  logic signed [POS_W-1:0] cly;
  logic signed [POS_W:0]   dx;
  logic signed [POS_W:0]   dy;
  logic [POS_W:0]          adx;
  logic [POS_W:0]          ady;
  ctx_t                    s1_nxt;
  ctx_t                    s1_r;

  always_comb begin
    if (in_data.center_x < in_data.box_min_x) clx = in_data.box_min_x;
    else if (in_data.center_x > in_data.box_max_x) clx = in_data.box_max_x;
    else clx = in_data.center_x;
    if (in_data.center_y < in_data.box_min_y) cly = in_data.box_min_y;
    else if (in_data.center_y > in_data.box_max_y) cly = in_data.box_max_y;
    else cly = in_data.center_y;
    dx  = (POS_W+1)'(in_data.center_x) - (POS_W+1)'(clx);
    dy  = (POS_W+1)'(in_data.center_y) - (POS_W+1)'(cly);
    adx = dx[POS_W] ? (POS_W+1)'(-dx) : dx;
    ady = dy[POS_W] ? (POS_W+1)'(-dy) : dy;
    s1_nxt.vld  = in_valid;
    s1_nxt.hit  = in_data.box_solid && (adx[POS_W:RAD_W] == '0)
                  && (ady[POS_W:RAD_W] == '0);
    s1_nxt.proj = in_data.is_projectile;
    s1_nxt.cx   = in_data.center_x;
    s1_nxt.cy   = in_data.center_y;
    s1_nxt.sx   = dx[POS_W];
    s1_nxt.sy   = dy[POS_W];
    s1_nxt.ax   = adx[RAD_W-1:0];
    s1_nxt.ay   = ady[RAD_W-1:0];
    s1_nxt.r    = in_data.radius;
  end

  // stage 2: squares
  ctx_t        s2_r;
  logic [31:0] xx_r;
  logic [31:0] yy_r;
  logic [31:0] rr_r;

  // stage 3: distance test
  logic [32:0] d2;
  sq_t         sq_in;

  always_comb begin
    d2 = 33'(xx_r) + 33'(yy_r);
    sq_in.ctx     = s2_r;
    sq_in.ctx.hit = s2_r.hit && (d2 != '0) && (d2 < 33'(rr_r));
    sq_in.rad     = d2[31:0];
    sq_in.rem     = '0;
    sq_in.root    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s1_r;
      xx_r <= 32'(s1_r.ax) * 32'(s1_r.ax);
      yy_r <= 32'(s1_r.ay) * 32'(s1_r.ay);
      rr_r <= 32'(s1_r.r) * 32'(s1_r.r);
    end
  end

  sq_t sq_q [NSQ+1];
  sq_t sq_reg;
  assign sq_q[0] = sq_reg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_reg.ctx.vld <= 1'b0;
    end else if (en) begin
      sq_reg <= sq_in;
    end
  end

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    cbpo_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (sq_q[i]),
      .d_o   (sq_q[i+1])
    );
  end

  // multiply stage: a * (r - s)
  ctx_t        m_r;
  logic [15:0] ms_r;
  logic [31:0] apx_r;
  logic [31:0] apy_r;
  logic [15:0] p;

  assign p = sq_q[NSQ].ctx.r - sq_q[NSQ].root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r.vld <= 1'b0;
    end else if (en) begin
      m_r   <= sq_q[NSQ].ctx;
      ms_r  <= sq_q[NSQ].root;
      apx_r <= 32'(sq_q[NSQ].ctx.ax) * 32'(p);
      apy_r <= 32'(sq_q[NSQ].ctx.ay) * 32'(p);
    end
  end

  dv_t dv_q [NDV+1];

  always_comb begin
    dv_q[0].ctx = m_r;
    dv_q[0].s   = ms_r;
    dv_q[0].rx  = {1'b0, apx_r, 1'b0} + 34'(ms_r);
    dv_q[0].ry  = {1'b0, apy_r, 1'b0} + 34'(ms_r);
    dv_q[0].qx  = '0;
    dv_q[0].qy  = '0;
  end

  for (genvar j = 0; j < NDV; j++) begin : g_dv
    cbpo_div_cell #(.K(NDV - 1 - j)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (dv_q[j]),
      .d_o   (dv_q[j+1])
    );
  end

  // output: apply offset, saturate
  localparam logic signed [POS_W+1:0] MAXV = (POS_W+2)'((64'sd1 <<< (POS_W-1)) - 1);
  localparam logic signed [POS_W+1:0] MINV = -MAXV - (POS_W+2)'(1);

  ctx_t                    fc;
  logic signed [POS_W+1:0] sx_sum;
  logic signed [POS_W+1:0] sy_sum;
  logic signed [POS_W+1:0] ox;
  logic signed [POS_W+1:0] oy;
  out_t                    out_nxt;
  out_t                    out_r;
  logic                    out_valid_r;

  always_comb begin
    fc = dv_q[NDV].ctx;
    ox = fc.sx ? -(POS_W+2)'(dv_q[NDV].qx) : (POS_W+2)'(dv_q[NDV].qx);
    oy = fc.sy ? -(POS_W+2)'(dv_q[NDV].qy) : (POS_W+2)'(dv_q[NDV].qy);
    sx_sum = (POS_W+2)'(fc.cx) + ox;
    sy_sum = (POS_W+2)'(fc.cy) + oy;
    out_nxt.new_x   = fc.cx;
    out_nxt.new_y   = fc.cy;
    out_nxt.pushed  = fc.hit;
    out_nxt.destroy = fc.hit && fc.proj;
    if (fc.hit) begin
      if (sx_sum > MAXV) out_nxt.new_x = MAXV[POS_W-1:0];
      else if (sx_sum < MINV) out_nxt.new_x = MINV[POS_W-1:0];
      else out_nxt.new_x = sx_sum[POS_W-1:0];
      if (sy_sum > MAXV) out_nxt.new_y = MAXV[POS_W-1:0];
      else if (sy_sum < MINV) out_nxt.new_y = MINV[POS_W-1:0];
      else out_nxt.new_y = sy_sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= fc.vld;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* tb/circle_box_push_out_checker.sv */
`timescale 1ns / 1ps
module circle_box_push_out_checker
  import cbpo_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_stall,
  input  in_t       in_data,
  input  wire logic out_valid,
  input  wire logic out_stall,
  input  out_t      out_data,
  output int        fail_count,
  output int        pending,
  output int        push_count,
  output int        result_count
);

  out_t resolved_q[$];

  function automatic longint clamp_axis(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint root;
    longint b;
    root = 0;
    for (int k = 20; k >= 0; k--) begin
      b = root | (longint'(1) << k);
      if (b * b <= v) root = b;
    end
    return root;
  endfunction

  function automatic longint push_offset(longint d, longint p, longint s);
    longint a;
    longint q;
    a = (d < 0) ? -d : d;
    q = (2 * a * p + s) / (2 * s);
    return (d < 0) ? -q : q;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(longint v);
    longint maxv;
    maxv = (longint'(1) << (POS_W - 1)) - 1;
    if (v > maxv) return POS_W'(maxv);
    if (v < -maxv - 1) return POS_W'(-maxv - 1);
    return POS_W'(v);
  endfunction

  function automatic out_t resolve(in_t t);
    out_t o;
    longint cx, cy, dx, dy, ax, ay, d2, r, s, p;
    cx = t.center_x;
    cy = t.center_y;
    r = t.radius;
    o.new_x = t.center_x;
    o.new_y = t.center_y;
    o.pushed = 1'b0;
    if (t.box_solid) begin
      dx = cx - clamp_axis(cx, longint'(t.box_min_x), longint'(t.box_max_x));
      dy = cy - clamp_axis(cy, longint'(t.box_min_y), longint'(t.box_max_y));
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax < 65536 && ay < 65536) begin
        d2 = ax * ax + ay * ay;
        if (d2 > 0 && d2 < r * r) begin
          s = int_sqrt(d2);
          p = r - s;
          o.new_x = sat_pos(cx + push_offset(dx, p, s));
          o.new_y = sat_pos(cy + push_offset(dy, p, s));
          o.pushed = 1'b1;
        end
      end
    end
    o.destroy = o.pushed & t.is_projectile;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  assign pending = resolved_q.size();

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      fail_count = 0;
      push_count <= 0;
      result_count <= 0;
    end else begin
      if (in_valid && !in_stall) resolved_q.push_back(resolve(in_data));
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (resolved_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $time);
          fail_count++;
        end else begin
          want = resolved_q.pop_front();
          if (want.pushed) push_count <= push_count + 1;
          if (out_data.new_x !== want.new_x)
            report_mismatch("new_x", out_data.new_x, want.new_x);
          if (out_data.new_y !== want.new_y)
            report_mismatch("new_y", out_data.new_y, want.new_y);
          if (out_data.pushed !== want.pushed)
            report_mismatch("pushed", out_data.pushed, want.pushed);
          if (out_data.destroy !== want.destroy)
            report_mismatch("destroy", out_data.destroy, want.destroy);
        end
      end
    end
  end

endmodule

/* tb/circle_box_push_out_top_test.sv */
`timescale 1ns / 1ps
module circle_box_push_out_top_test;
  import cbpo_pkg::*;

  localparam int LATENCY = 38;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IN_W = $bits(in_t);

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   push_count;
  int   result_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   quiet_cycles;
  int   items_sent;
  int   directed_count;

  circle_box_push_out_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  circle_box_push_out_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending),
    .push_count(push_count), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver stall, randomized each cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic logic signed [POS_W-1:0] rand_pos();
    case ($urandom_range(5))
      0: return {1'b0, {(POS_W-1){1'b1}}};
      1: return {1'b1, {(POS_W-1){1'b0}}};
      default: return POS_W'($urandom());
    endcase
  endfunction

  // circle near a box so the push path is exercised
  function automatic in_t near_item();
    in_t t;
    int  w, h, off;
    t.radius = RAD_W'(($urandom_range(3) == 0) ? $urandom() : $urandom_range(20000, 1));
    if ($urandom_range(9) == 0) t.radius = 16'hFFFF;
    t.box_min_x = rand_pos();
    t.box_min_y = rand_pos();
    if ($urandom_range(7) == 0) begin
      t.box_min_x = POS_W'(int'($urandom_range(2000)) + 32'sh7F0000);
      t.box_min_y = POS_W'(-32'sh7FFF00 - int'($urandom_range(200)));
    end
    w = $urandom_range(40000);
    h = $urandom_range(40000);
    t.box_max_x = POS_W'(t.box_min_x + w);
    t.box_max_y = POS_W'(t.box_min_y + h);
    if ($urandom_range(9) == 0) t.box_max_x = POS_W'(t.box_min_x - w);  // inverted
    off = int'($urandom_range(2 * t.radius + 2)) - int'(t.radius) - 1;
    t.center_x = POS_W'(($urandom_range(1) ? t.box_max_x : t.box_min_x) + off);
    off = int'($urandom_range(2 * t.radius + 2)) - int'(t.radius) - 1;
    t.center_y = POS_W'(($urandom_range(1) ? t.box_max_y : t.box_min_y) + off);
    t.box_solid = ($urandom_range(9) != 0);
    t.is_projectile = 1'($urandom_range(1));
    return t;
  endfunction

  function automatic in_t noise_item();
    in_t t;
    t = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    t.center_x = rand_pos();
    t.center_y = rand_pos();
    t.box_min_x = rand_pos();
    t.box_max_y = rand_pos();
    return t;
  endfunction

  function automatic in_t make_item(int cx, int cy, int r, int x0, int y0, int x1,
                                    int y1, bit solid, bit proj);
    in_t t;
    t.center_x = POS_W'(cx);
    t.center_y = POS_W'(cy);
    t.radius = RAD_W'(r);
    t.box_min_x = POS_W'(x0);
    t.box_min_y = POS_W'(y0);
    t.box_max_x = POS_W'(x1);
    t.box_max_y = POS_W'(y1);
    t.box_solid = solid;
    t.is_projectile = proj;
    return t;
  endfunction

  task automatic send_item(in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++)
      send_item(($urandom_range(9) < 8) ? near_item() : noise_item());
  endtask

  localparam int PMAX = 8388607;
  localparam int PMIN = -8388608;

  initial begin
    in_in_reset();
    // directed: edges of the fields and each special case
    send_item(make_item(100, 100, 4096, 0, 0, 50, 50, 1'b0, 1'b1));   // not solid
    send_item(make_item(10, 10, 4096, 0, 0, 50, 50, 1'b1, 1'b1));     // inside
    send_item(make_item(50, 20, 4096, 0, 0, 50, 50, 1'b1, 1'b0));     // on edge
    send_item(make_item(60, 20, 0, 0, 0, 50, 50, 1'b1, 1'b1));        // zero radius
    send_item(make_item(60, 20, 10, 0, 0, 50, 50, 1'b1, 1'b1));       // at radius
    send_item(make_item(60, 20, 11, 0, 0, 50, 50, 1'b1, 1'b1));       // push
    send_item(make_item(-5, -7, 65535, 0, 0, 50, 50, 1'b1, 1'b0));    // corner
    send_item(make_item(65536, 0, 65535, 0, 0, 0, 0, 1'b1, 1'b1));    // too far
    send_item(make_item(65535, 0, 65535, 0, 0, 0, 0, 1'b1, 1'b1));
    send_item(make_item(PMAX - 3, 0, 65535, PMIN, -9, PMAX - 5, 9, 1'b1, 1'b1));
    send_item(make_item(PMIN + 3, PMIN, 65535, PMIN + 5, PMIN + 1, PMAX, 9, 1'b1, 1'b0));
    send_item(make_item(PMAX, PMAX, 65535, PMAX - 1, PMAX - 1, PMAX - 1, PMAX - 1, 1'b1, 1'b1));
    send_item(make_item(PMIN, PMIN, 65535, PMIN + 1, PMIN + 1, PMIN + 1, PMIN + 1, 1'b1, 1'b1));
    send_item(make_item(30, 30, 4096, 50, 50, 0, 0, 1'b1, 1'b1));     // inverted, below
    send_item(make_item(60, 20, 4096, 50, 0, 0, 50, 1'b1, 1'b0));     // inverted x
    send_item(make_item(PMAX, PMIN, 65535, PMIN, PMIN, PMAX, PMAX, 1'b1, 1'b1));
    send_item(make_item(1, -1, 3, 0, 0, 0, 0, 1'b1, 1'b1));
    send_item(make_item(-1, 0, 2, 0, 0, 0, 0, 1'b1, 1'b1));
    directed_count = items_sent;
    drain_results();

    send_idle_pct = 36;
    recv_idle_pct = 87;
    run_random(550);
    // hold the sender until the pipe is empty
    drain_results();
    send_idle_pct = 87;
    recv_idle_pct = 36;
    run_random(550);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(550);
    drain_results();
    repeat (LATENCY + 5) @(posedge clk);

    $display("Sent %0d items (%0d directed), checked %0d results, %0d pushed.",
             items_sent, directed_count, result_count, push_count);
    $display("Idle mixes: sender 36/receiver 87, 87/36 and none.");
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  task automatic in_in_reset();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

endmodule
